### rtl/core/gmlp_pkg.sv
// Shared types, codes and limits of the gopher menu line parser.
package gmlp_pkg;

	// Field size limits in bytes
	localparam int DISPLAY_CAP  = 128;
	localparam int SELECTOR_CAP = 256;
	localparam int HOST_CAP     = 128;
	localparam int PORT_MAX_LEN = 5;

	localparam int LEN_W   = 9;
	localparam int VALUE_W = 17;

	// Byte codes of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_TYPE     = 3'd0,
		KIND_DISPLAY  = 3'd1,
		KIND_SELECTOR = 3'd2,
		KIND_HOST     = 3'd3,
		KIND_STATUS   = 3'd4
	} kind_t;

	// Field being parsed
	typedef enum logic [5:0] {
		FLD_TYPE     = 6'b000001,
		FLD_DISPLAY  = 6'b000010,
		FLD_SELECTOR = 6'b000100,
		FLD_HOST     = 6'b001000,
		FLD_PORT     = 6'b010000,
		FLD_DONE     = 6'b100000
	} field_t;

	// Port number reader phase
	typedef enum logic [3:0] {
		PH_BLANK = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	// Port number reader state
	typedef struct packed {
		phase_t              phase;
		logic [VALUE_W-1:0]  value;
		logic                negative;
	} port_st_t;

	localparam port_st_t PORT_ST_RESET = '{phase: PH_BLANK, value: '0, negative: 1'b0};

endpackage

### rtl/core/gmlp_port_reader.sv
// Next-state logic of the decimal port number reader.
module gmlp_port_reader (
	input  logic [7:0]        ch,
	input  gmlp_pkg::port_st_t cur,
	output gmlp_pkg::port_st_t nxt
);
	import gmlp_pkg::*;

	logic               digit;
	logic               blank;
	logic               sign;
	logic [VALUE_W-1:0] acc;

	assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign blank = (ch == CH_SPACE) || (ch == CH_VT) || (ch == CH_FF);
	assign sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

	// Accumulate value * 10 + digit, wrapped to the value width
	assign acc = (cur.value << 3) + (cur.value << 1)
		+ {{(VALUE_W-4){1'b0}}, ch[3:0]};

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_BLANK: begin
				if (blank) begin
					nxt = cur;
				end else if (sign) begin
					nxt.negative = (ch == CH_MINUS);
					nxt.phase    = PH_SIGN;
				end else if (digit) begin
					nxt.value = acc;
					nxt.phase = PH_DIGIT;
				end else begin
					nxt.phase = PH_STOP;
				end
			end
			PH_SIGN, PH_DIGIT: begin
				if (digit) begin
					nxt.value = acc;
					nxt.phase = PH_DIGIT;
				end else begin
					nxt.phase = PH_STOP;
				end
			end
			PH_STOP: nxt = cur;
			default: nxt = cur;
		endcase
	end

endmodule

### rtl/core/gopher_menu_line_parser.sv
// Top level of the gopher menu line parser: field tracking and result register.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall   | ch, end_of_line
//   result  | out       | out_valid/out_stall | kind, ch_out, port, error, last
//
// One item per cycle while in_stall is low; the result of an item that yields one
// appears in the cycle after it is accepted, set by the single result register.
// Reset clears the field tracker, the port reader and the result valid flag.
// in_stall follows out_stall while a result is held, so a new item enters in the
// same cycle the held result is taken.
module gopher_menu_line_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           ch,
	input  logic                 end_of_line,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gmlp_pkg::kind_t      kind,
	output logic [7:0]           ch_out,
	output logic [15:0]          port,
	output logic                 error,
	output logic                 last
);
	import gmlp_pkg::*;

	localparam logic [LEN_W:0] DISPLAY_LIM  = (LEN_W+1)'(DISPLAY_CAP);
	localparam logic [LEN_W:0] SELECTOR_LIM = (LEN_W+1)'(SELECTOR_CAP);
	localparam logic [LEN_W:0] HOST_LIM     = (LEN_W+1)'(HOST_CAP);
	localparam logic [LEN_W-1:0] PORT_LIM   = LEN_W'(PORT_MAX_LEN);

	field_t             field_q, field_d;
	logic [LEN_W-1:0]   len_q, len_d;
	port_st_t           pst_q, pst_d, pst_step;
	logic               line_err_q, line_err_d;
	logic               nul_q, nul_d;

	logic               res_valid;
	kind_t              res_kind;
	logic [7:0]         res_ch;
	logic [15:0]        res_port;
	logic               res_err;
	logic               res_last;

	logic               out_valid_q;
	kind_t              kind_q;
	logic [7:0]         ch_out_q;
	logic [15:0]        port_q;
	logic               error_q;
	logic               last_q;

	logic               accept;
	logic [LEN_W:0]     len_inc;
	logic [LEN_W:0]     cap;
	logic               status_err;
	kind_t              field_kind;
	field_t             field_after_tab;

	// Hold input while a result waits
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	gmlp_port_reader u_port_reader (
		.ch  (ch),
		.cur (pst_q),
		.nxt (pst_step)
	);

	assign len_inc = {1'b0, len_q} + 1'b1;

	// Select cap, result kind and following field for the text fields
	always_comb begin
		unique case (field_q)
			FLD_DISPLAY: begin
				cap             = DISPLAY_LIM;
				field_kind      = KIND_DISPLAY;
				field_after_tab = FLD_SELECTOR;
			end
			FLD_SELECTOR: begin
				cap             = SELECTOR_LIM;
				field_kind      = KIND_SELECTOR;
				field_after_tab = FLD_HOST;
			end
			default: begin
				cap             = HOST_LIM;
				field_kind      = KIND_HOST;
				field_after_tab = FLD_PORT;
			end
		endcase
	end

	// Judge the line at the end marker
	always_comb begin
		status_err = line_err_q;
		if (field_q != FLD_PORT && field_q != FLD_DONE) status_err = 1'b1;
		if (len_q == '0 || len_q > PORT_LIM) status_err = 1'b1;
		if (pst_q.negative && pst_q.value != '0) status_err = 1'b1;
		if (pst_q.value == '0 || pst_q.value[VALUE_W-1]) status_err = 1'b1;
	end

	// Advance the parser by one item
	always_comb begin
		field_d    = field_q;
		len_d      = len_q;
		pst_d      = pst_q;
		line_err_d = line_err_q;
		nul_d      = nul_q;
		res_valid  = 1'b0;
		res_kind   = KIND_TYPE;
		res_ch     = '0;
		res_port   = '0;
		res_err    = 1'b0;
		res_last   = 1'b0;

		if (end_of_line) begin
			res_valid  = 1'b1;
			res_kind   = KIND_STATUS;
			res_err    = status_err;
			res_port   = status_err ? 16'd0 : pst_q.value[15:0];
			res_last   = 1'b1;
			field_d    = FLD_TYPE;
			len_d      = '0;
			pst_d      = PORT_ST_RESET;
			line_err_d = 1'b0;
			nul_d      = 1'b0;
		end else if (nul_q || line_err_q) begin
			// drop bytes after a terminator or a rejection
			res_valid = 1'b0;
		end else if (ch == CH_NUL) begin
			nul_d = 1'b1;
		end else begin
			unique case (field_q)
				FLD_TYPE: begin
					field_d   = FLD_DISPLAY;
					len_d     = '0;
					res_valid = 1'b1;
					res_kind  = KIND_TYPE;
					res_ch    = ch;
				end
				FLD_DISPLAY, FLD_SELECTOR, FLD_HOST: begin
					if (ch == CH_TAB) begin
						field_d = field_after_tab;
						len_d   = '0;
					end else if (len_inc >= cap) begin
						line_err_d = 1'b1;
					end else begin
						len_d     = len_inc[LEN_W-1:0];
						res_valid = 1'b1;
						res_kind  = field_kind;
						res_ch    = ch;
					end
				end
				FLD_PORT: begin
					if (ch == CH_CR || ch == CH_LF || ch == CH_TAB) begin
						field_d = FLD_DONE;
					end else if (len_q >= PORT_LIM) begin
						line_err_d = 1'b1;
					end else begin
						len_d = len_inc[LEN_W-1:0];
						pst_d = pst_step;
					end
				end
				FLD_DONE: res_valid = 1'b0;
				default:  res_valid = 1'b0;
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= FLD_TYPE;
			len_q      <= '0;
			pst_q      <= PORT_ST_RESET;
			line_err_q <= 1'b0;
			nul_q      <= 1'b0;
		end else if (accept) begin
			field_q    <= field_d;
			len_q      <= len_d;
			pst_q      <= pst_d;
			line_err_q <= line_err_d;
			nul_q      <= nul_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= accept && res_valid;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			kind_q   <= res_kind;
			ch_out_q <= res_ch;
			port_q   <= res_port;
			error_q  <= res_err;
			last_q   <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign ch_out    = ch_out_q;
	assign port      = port_q;
	assign error     = error_q;
	assign last      = last_q;

endmodule

### rtl/core/gmlp_checker.sv
// Port-level assertions for the gopher menu line parser, bound to the top level.
module gmlp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            end_of_line,
	input logic            out_valid,
	input logic            out_stall,
	input gmlp_pkg::kind_t kind,
	input logic [7:0]      ch_out,
	input logic [15:0]     port,
	input logic            error,
	input logic            last
);
	import gmlp_pkg::*;

	// Keep a stalled result on the port
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(port))
		else $error("stalled result dropped or changed");

	// End marker closes the line with a status item next cycle
	a_eol_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_line |=> out_valid && last && kind == KIND_STATUS)
		else $error("end marker gave no status item");

	// Only status items carry last, port and error
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_STATUS |-> !last && !error && port == 16'd0)
		else $error("byte item carries status fields");

	// Rejected line reports port zero, accepted line a nonzero port
	a_status_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> ch_out == 8'd0 && (error == (port == 16'd0)))
		else $error("status port inconsistent with error");

endmodule

bind gopher_menu_line_parser gmlp_checker u_gmlp_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the gopher menu line parser: directed lines, then random lines.
module testbench;
	import gmlp_pkg::*;

	localparam int ITEM_GOAL   = 1450;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_WAIT  = 10;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch_out;
		logic [15:0] port;
		logic        error;
		logic        last;
	} menu_result_t;

	typedef struct {
		logic [7:0]   c;
		logic         eol;
		bit           typed;
		menu_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  ch = 8'h00;
	logic        end_of_line = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	kind_t       kind;
	logic [7:0]  ch_out;
	logic [15:0] port;
	logic        error;
	logic        last;

	// Parser state as predicted from the accepted items
	field_t      fld;
	logic [8:0]  fld_len;
	phase_t      pphase;
	logic [16:0] pval;
	logic        pneg;
	logic        rejected;
	logic        text_ended;

	menu_result_t menu_results_due[$];
	dir_row_t     plan[$];
	logic [7:0]   line_bytes[$];
	int           send_gap_pct = 11;
	int           stall_pct = 64;
	int           items_sent = 0;
	int           mismatches = 0;
	int           cycles = 0;

	gopher_menu_line_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.end_of_line (end_of_line),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.ch_out      (ch_out),
		.port        (port),
		.error       (error),
		.last        (last)
	);

	always #4 clk = ~clk;

	// Return the parser to the start of a line
	function automatic void clear_parser();
		fld = FLD_TYPE;
		fld_len = '0;
		pphase = PH_BLANK;
		pval = '0;
		pneg = 1'b0;
		rejected = 1'b0;
		text_ended = 1'b0;
	endfunction

	// Advance the parser by one item; report whether it yields a result
	function automatic bit parse_menu_byte(input logic [7:0] c, input logic eol,
			output menu_result_t r);
		logic   digit;
		logic   blank;
		int     cap;
		field_t nxt;
		r = '0;
		digit = (c >= CH_ZERO && c <= CH_NINE);
		blank = (c == CH_SPACE || c == CH_VT || c == CH_FF);
		if (eol) begin
			r.kind = KIND_STATUS;
			r.last = 1'b1;
			r.error = rejected || (fld != FLD_PORT && fld != FLD_DONE) || fld_len == 0 ||
				fld_len > PORT_MAX_LEN || (pneg && pval != 0) || pval == 0 ||
				pval > 17'd65535;
			if (!r.error)
				r.port = pval[15:0];
			clear_parser();
			return 1'b1;
		end
		if (text_ended || rejected)
			return 1'b0;
		if (c == CH_NUL) begin
			text_ended = 1'b1;
			return 1'b0;
		end
		case (fld)
		FLD_TYPE: begin
			fld = FLD_DISPLAY;
			fld_len = '0;
			r.kind = KIND_TYPE;
			r.ch_out = c;
			return 1'b1;
		end
		FLD_DISPLAY, FLD_SELECTOR, FLD_HOST: begin
			case (fld)
			FLD_DISPLAY: begin
				cap = DISPLAY_CAP;
				r.kind = KIND_DISPLAY;
				nxt = FLD_SELECTOR;
			end
			FLD_SELECTOR: begin
				cap = SELECTOR_CAP;
				r.kind = KIND_SELECTOR;
				nxt = FLD_HOST;
			end
			default: begin
				cap = HOST_CAP;
				r.kind = KIND_HOST;
				nxt = FLD_PORT;
			end
			endcase
			if (c == CH_TAB) begin
				fld = nxt;
				fld_len = '0;
				return 1'b0;
			end
			if (fld_len + 1 >= cap) begin
				rejected = 1'b1;
				return 1'b0;
			end
			fld_len = fld_len + 1'b1;
			r.ch_out = c;
			return 1'b1;
		end
		FLD_PORT: begin
			if (c == CH_CR || c == CH_LF || c == CH_TAB) begin
				fld = FLD_DONE;
				return 1'b0;
			end
			if (fld_len >= PORT_MAX_LEN) begin
				rejected = 1'b1;
				return 1'b0;
			end
			fld_len = fld_len + 1'b1;
			// Read the number the way strtol does
			if (pphase == PH_BLANK && blank) begin
			end else if (pphase == PH_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
				pneg = (c == CH_MINUS);
				pphase = PH_SIGN;
			end else if (pphase != PH_STOP) begin
				if (digit) begin
					pval = pval * 17'd10 + {9'd0, c - CH_ZERO};
					pphase = PH_DIGIT;
				end else begin
					pphase = PH_STOP;
				end
			end
			return 1'b0;
		end
		default: return 1'b0;
		endcase
	endfunction

	// Drive one item, hold it until taken, then log what it should produce
	task automatic send_item(input logic [7:0] c, input logic eol, input bit typed,
			input menu_result_t want);
		menu_result_t r;
		bit           has;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		ch = c;
		end_of_line = eol;
		do @(posedge clk); while (in_stall);
		has = parse_menu_byte(c, eol, r);
		if (typed)
			menu_results_due.push_back(want);
		else if (has)
			menu_results_due.push_back(r);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold off the sender until every logged result has come out
	task automatic drain();
		in_valid = 1'b0;
		while (menu_results_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic void add_row(input logic [7:0] c, input logic eol, input bit typed,
			input kind_t k, input logic [7:0] b, input logic [15:0] pv, input logic err);
		dir_row_t row;
		row.c = c;
		row.eol = eol;
		row.typed = typed;
		row.want = '{kind: k, ch_out: b, port: pv, error: err, last: (k == KIND_STATUS)};
		plan.push_back(row);
	endfunction

	// Append n text bytes with no tab and no zero byte
	function automatic void push_text(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(1, 255));
			if (b == CH_TAB)
				b = CH_SPACE;
			line_bytes.push_back(b);
		end
	endfunction

	// Append a port field: blanks, sign, digits, trailing junk, terminator, stray text
	function automatic void push_port();
		int         v;
		logic [7:0] digits[$];
		repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) begin
			case ($urandom_range(2))
			0: line_bytes.push_back(CH_SPACE);
			1: line_bytes.push_back(CH_VT);
			default: line_bytes.push_back(CH_FF);
			endcase
		end
		case ($urandom_range(7))
		0: line_bytes.push_back(CH_PLUS);
		1: line_bytes.push_back(CH_MINUS);
		default: ;
		endcase
		case ($urandom_range(9))
		0: v = 65535;
		1: v = 65536;
		2: v = 0;
		3: v = -1;
		4: v = $urandom_range(1, 9);
		default: v = $urandom_range(1, 99999);
		endcase
		if (v >= 0) begin
			if ($urandom_range(5) == 0)
				line_bytes.push_back(CH_ZERO);
			do begin
				digits.push_front(8'(CH_ZERO + v % 10));
				v = v / 10;
			end while (v > 0);
			foreach (digits[i])
				line_bytes.push_back(digits[i]);
		end
		if ($urandom_range(5) == 0)
			line_bytes.push_back(8'($urandom_range(8'h3a, 8'h7e)));
		case ($urandom_range(4))
		0: ;
		1: line_bytes.push_back(CH_CR);
		2: line_bytes.push_back(CH_LF);
		3: line_bytes.push_back(CH_TAB);
		default: begin
			line_bytes.push_back(CH_CR);
			line_bytes.push_back(CH_LF);
		end
		endcase
		if ($urandom_range(3) == 0)
			push_text($urandom_range(1, 4));
	endfunction

	// Build a line with all fields; long_field picks one text field to run near its cap
	function automatic void build_menu_line(input int long_field);
		int n;
		line_bytes.push_back(8'($urandom_range(1, 255)));
		for (int f = 1; f <= 3; f++) begin
			if (f == long_field)
				n = (f == 1 ? DISPLAY_CAP : (f == 2 ? SELECTOR_CAP : HOST_CAP)) +
					$urandom_range(0, 3) - 2;
			else
				n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			push_text(n);
			line_bytes.push_back(CH_TAB);
		end
		push_port();
	endfunction

	// Receiver: stall at the current rate
	always @(negedge clk)
		out_stall = ($urandom_range(99) < stall_pct);

	// Compare each taken result with the oldest one due
	always @(posedge clk) begin : check_results
		menu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (menu_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind %0d ch %h port %0d error %b last %b",
						kind, ch_out, port, error, last);
			end else begin
				want = menu_results_due.pop_front();
				if (kind !== want.kind || ch_out !== want.ch_out || port !== want.port ||
						error !== want.error || last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("mismatch: expected kind %0d ch %h port %0d error %b last %b,",
							want.kind, want.ch_out, want.port, want.error, want.last);
						$display(" got kind %0d ch %h port %0d error %b last %b",
							kind, ch_out, port, error, last);
					end
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int pick;
		int k;
		clear_parser();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty line
		add_row(8'h5a, 1'b1, 1'b1, KIND_STATUS, 8'h00, 16'd0, 1'b1);
		// Lone dot
		add_row(8'h2e, 1'b0, 1'b1, KIND_TYPE, 8'h2e, 16'd0, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, KIND_STATUS, 8'h00, 16'd0, 1'b1);
		// Short line with every field
		add_row(8'h31, 1'b0, 1'b1, KIND_TYPE, 8'h31, 16'd0, 1'b0);
		add_row(8'h61, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h62, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h63, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h37, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'hff, 1'b1, 1'b1, KIND_STATUS, 8'h00, 16'd7, 1'b0);
		// Top type byte, empty text fields, top port value
		add_row(8'hff, 1'b0, 1'b1, KIND_TYPE, 8'hff, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(CH_TAB, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h36, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h35, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h35, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h33, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h35, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, KIND_STATUS, 8'h00, 16'hffff, 1'b0);
		// Zero byte ends the text; what follows is ignored
		add_row(CH_NUL, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h31, 1'b0, 1'b0, KIND_TYPE, 8'h00, 16'd0, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, KIND_STATUS, 8'h00, 16'd0, 1'b1);
		foreach (plan[i])
			send_item(plan[i].c, plan[i].eol, plan[i].typed, plan[i].want);

		// Random lines in three idling phases, drained between phases
		for (int p = 0; p < 3; p++) begin
			send_gap_pct = (p == 0) ? 11 : ((p == 1) ? 64 : 0);
			stall_pct = (p == 0) ? 64 : ((p == 1) ? 11 : 0);
			while (items_sent < (p + 1) * ITEM_GOAL / 3) begin
				line_bytes.delete();
				pick = $urandom_range(99);
				if (pick < 3) begin
					build_menu_line($urandom_range(1, 3));
				end else if (pick < 73) begin
					build_menu_line(0);
				end else if (pick < 90) begin
					// Break a good line: cut it, plant a zero byte, or drop a byte
					build_menu_line(0);
					k = $urandom_range(line_bytes.size() - 1);
					case ($urandom_range(2))
					0: while (line_bytes.size() > k) void'(line_bytes.pop_back());
					1: line_bytes[k] = CH_NUL;
					default: line_bytes.delete(k);
					endcase
				end else begin
					repeat ($urandom_range(12))
						line_bytes.push_back(8'($urandom_range(255)));
				end
				foreach (line_bytes[i])
					send_item(line_bytes[i], 1'b0, 1'b0, '0);
				send_item(8'($urandom), 1'b1, 1'b0, '0);
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && menu_results_due.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
